[sv/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants for the servo slew position controller
// Payload structs, command and register codes, reset calibration and the
// request/response bundles of the shared divider.
// ----------------------------------------------------------------------------
package ssp_pkg;

  // Command codes carried in the operation field
  typedef enum logic [1:0] {
    OP_INIT       = 2'd0,
    OP_SET_ANGLE  = 2'd1,
    OP_SET_PULSE  = 2'd2,
    OP_UPDATE     = 2'd3
  } op_e;

  // Motion state codes reported with every result
  localparam logic [1:0] MS_DISABLED = 2'd0;
  localparam logic [1:0] MS_HOLDING  = 2'd1;
  localparam logic [1:0] MS_MOVING   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_CENTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_CENTER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MAX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SLEW     = 3'd6;

  // Calibration reset values
  localparam logic [15:0]        RST_PULSE_MIN    = 16'd1000;
  localparam logic [15:0]        RST_PULSE_CENTER = 16'd1500;
  localparam logic [15:0]        RST_PULSE_MAX    = 16'd2000;
  localparam logic signed [15:0] RST_ANGLE_MIN    = -16'sd9000;
  localparam logic signed [15:0] RST_ANGLE_CENTER = 16'sd0;
  localparam logic signed [15:0] RST_ANGLE_MAX    = 16'sd9000;
  localparam logic [15:0]        RST_MAX_SLEW     = 16'd1000;

  // Elapsed time cap and the ms-per-second divisor of the slew step
  localparam int unsigned DT_W = 7;
  localparam logic [DT_W-1:0] DT_CAP_MS = 7'd100;
  localparam logic [15:0] MS_PER_S = 16'd1000;

  // Shared divider geometry
  localparam int unsigned DIV_NUM_W = 32;
  localparam int unsigned DIV_DEN_W = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W);

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] target_angle;
    logic [15:0]        target_pulse;
    logic [31:0]        now_ms;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic        limited;
    logic [15:0] current_pulse;
    logic [1:0]  motion_state;
  } out_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

[sv/ssp_div.sv]
// ----------------------------------------------------------------------------
// ssp_div: shared iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses once the
// quotient register holds the final value.
// ----------------------------------------------------------------------------
module ssp_div (
  input  logic              clk,
  input  logic              rst,
  input  ssp_pkg::div_req_t req,
  output ssp_pkg::div_rsp_t rsp
);
  import ssp_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] den;

  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;
  logic [DIV_DEN_W-1:0] rem_next;
  logic [DIV_NUM_W-1:0] quo_next;

  // One trial subtraction per cycle
  always_comb begin
    rem_sh   = {rem, quo[DIV_NUM_W-1]};
    diff     = rem_sh - {1'b0, den};
    fits     = rem_sh >= {1'b0, den};
    rem_next = fits ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    quo_next = {quo[DIV_NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt  <= cnt + 1'b1;
      busy <= cnt != DIV_CNT_W'(DIV_NUM_W - 1);
      done <= cnt == DIV_CNT_W'(DIV_NUM_W - 1);
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath registers need no reset
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

[sv/servo_slew_position_controller.sv]
// ----------------------------------------------------------------------------
// servo_slew_position_controller: servo pulse controller with slew limiting
// Calibration registers, command sequencer, one shared multiplier and the
// shared iterative divider for angle interpolation and slew steps.
// ----------------------------------------------------------------------------
// One command is taken at a time and in_stall stays high until its result has
// been loaded into the output register. Init, set-pulse and any refused
// command skip the divider; set-angle and update go through the restoring
// divider that both share (one quotient bit per cycle), with the clamp,
// multiply, start, finish and load steps around it. The output
// register lets a result wait for the consumer while the block returns to idle
// and takes the next command. Calibration writes land in a register copy that
// is latched only by a successful init; write them while no command is in
// flight.
// ----------------------------------------------------------------------------
module servo_slew_position_controller (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_write,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]      cfg_data,
  // command channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ssp_pkg::in_t                        in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output ssp_pkg::out_t                       out_data
);
  import ssp_pkg::*;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PREP  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_START = 6'b001000,
    ST_WAIT  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  // Register copy written by the configuration port
  logic [15:0]        cfg_pmin, cfg_pcen, cfg_pmax, cfg_slew;
  logic signed [15:0] cfg_amin, cfg_acen, cfg_amax;

  // Calibration latched by a successful init
  logic [15:0]        h_pmin, h_pcen, h_pmax, h_slew;
  logic signed [15:0] h_amin, h_acen, h_amax;

  // Controller state
  logic        initialized;
  logic [15:0] cur_pulse;
  logic [15:0] tgt_pulse;
  logic [31:0] last_time;
  logic [1:0]  motion;

  // Command held for the length of its work
  logic [1:0]         op_r;
  logic signed [15:0] angle_r;
  logic [15:0]        pulse_r;
  logic [31:0]        now_r;

  // Operands prepared for the multiply/divide
  logic [15:0]    seg_dx;
  logic [15:0]    seg_dy_mag;
  logic           seg_dy_neg;
  logic [15:0]    seg_den;
  logic [15:0]    seg_y0;
  logic [DT_W-1:0] dt_r;
  logic           lim_r;
  logic [31:0]    prod;

  // Result fields waiting for the output register
  logic res_ok;
  logic res_lim;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // --------------------------------------------------------------------------
  // Configuration writes; an index beyond the list is dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_pmin <= RST_PULSE_MIN;
      cfg_pcen <= RST_PULSE_CENTER;
      cfg_pmax <= RST_PULSE_MAX;
      cfg_amin <= RST_ANGLE_MIN;
      cfg_acen <= RST_ANGLE_CENTER;
      cfg_amax <= RST_ANGLE_MAX;
      cfg_slew <= RST_MAX_SLEW;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PULSE_MIN:    cfg_pmin <= cfg_data;
        REG_PULSE_CENTER: cfg_pcen <= cfg_data;
        REG_PULSE_MAX:    cfg_pmax <= cfg_data;
        REG_ANGLE_MIN:    cfg_amin <= $signed(cfg_data);
        REG_ANGLE_CENTER: cfg_acen <= $signed(cfg_data);
        REG_ANGLE_MAX:    cfg_amax <= $signed(cfg_data);
        REG_MAX_SLEW:     cfg_slew <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Preparation logic: calibration check, clamps, segment choice, elapsed time
  // --------------------------------------------------------------------------
  logic               calib_valid;
  logic signed [15:0] ang_cl;
  logic               ang_lim;
  logic               lower_seg;
  logic signed [15:0] seg_x0, seg_x1;
  logic [15:0]        seg_y1;
  logic [15:0]        y0_sel;
  logic signed [16:0] dx17, den17;
  logic signed [16:0] dy17;
  logic [16:0]        dy_abs17;
  logic [31:0]        dt_raw;
  logic [DT_W-1:0]    dt_cap;
  logic [15:0]        p_lo, p_hi;
  logic [15:0]        pulse_cl;
  logic               pulse_lim;

  always_comb begin
    calib_valid = (cfg_slew != '0) && (cfg_amin < cfg_acen) && (cfg_acen < cfg_amax) &&
                  (((cfg_pmin < cfg_pcen) && (cfg_pcen < cfg_pmax)) ||
                   ((cfg_pmin > cfg_pcen) && (cfg_pcen > cfg_pmax)));

    // Clamp the requested angle to the latched limits
    ang_cl  = angle_r;
    ang_lim = 1'b0;
    if (angle_r < h_amin) begin
      ang_cl  = h_amin;
      ang_lim = 1'b1;
    end else if (angle_r > h_amax) begin
      ang_cl  = h_amax;
      ang_lim = 1'b1;
    end

    // Pick the interpolation segment
    lower_seg = ang_cl <= h_acen;
    seg_x0    = lower_seg ? h_amin : h_acen;
    seg_x1    = lower_seg ? h_acen : h_amax;
    y0_sel    = lower_seg ? h_pmin : h_pcen;
    seg_y1    = lower_seg ? h_pcen : h_pmax;
    dx17      = 17'(ang_cl) - 17'(seg_x0);
    den17     = 17'(seg_x1) - 17'(seg_x0);
    dy17      = $signed({1'b0, seg_y1}) - $signed({1'b0, y0_sel});
    dy_abs17  = dy17[16] ? 17'(-dy17) : 17'(dy17);

    // Elapsed time, wrapping, capped
    dt_raw = now_r - last_time;
    dt_cap = (dt_raw > 32'(DT_CAP_MS)) ? DT_CAP_MS : dt_raw[DT_W-1:0];

    // Clamp the requested pulse to the endpoint span
    p_lo      = (h_pmin < h_pmax) ? h_pmin : h_pmax;
    p_hi      = (h_pmin > h_pmax) ? h_pmin : h_pmax;
    pulse_cl  = pulse_r;
    pulse_lim = 1'b0;
    if (pulse_r < p_lo) begin
      pulse_cl  = p_lo;
      pulse_lim = 1'b1;
    end else if (pulse_r > p_hi) begin
      pulse_cl  = p_hi;
      pulse_lim = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier: segment product or slew times elapsed time
  // --------------------------------------------------------------------------
  logic        is_angle;
  logic [15:0] mul_a, mul_b;

  assign is_angle = op_r == OP_SET_ANGLE;
  assign mul_a    = is_angle ? seg_dx : h_slew;
  assign mul_b    = is_angle ? seg_dy_mag : {{(16 - DT_W){1'b0}}, dt_r};

  // --------------------------------------------------------------------------
  // Shared divider
  // --------------------------------------------------------------------------
  assign div_req.start = state == ST_START;
  assign div_req.num   = prod;
  assign div_req.den   = is_angle ? seg_den : MS_PER_S;

  ssp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Finish logic: interpolated pulse and slew-limited move
  // --------------------------------------------------------------------------
  logic [15:0]        quo16;
  logic signed [17:0] p18;
  logic               p_in_range;
  logic [15:0]        step;
  logic [16:0]        up_sum;
  logic [15:0]        gap;
  logic [15:0]        cur_new;

  always_comb begin
    quo16      = div_rsp.quo[15:0];
    // Truncation toward zero: divide magnitudes, then apply the sign
    p18        = seg_dy_neg ? $signed({2'b00, seg_y0}) - $signed({2'b00, quo16})
                            : $signed({2'b00, seg_y0}) + $signed({2'b00, quo16});
    p_in_range = (p18 >= 18'sd0) && (p18 <= 18'sd65535);

    // At least one microsecond of movement whenever time has passed
    step = ((dt_r != '0) && (quo16 == '0)) ? 16'd1 : quo16;

    up_sum  = {1'b0, cur_pulse} + {1'b0, step};
    gap     = cur_pulse - tgt_pulse;
    cur_new = cur_pulse;
    if (cur_pulse < tgt_pulse) begin
      cur_new = (up_sum < {1'b0, tgt_pulse}) ? up_sum[15:0] : tgt_pulse;
    end else if (cur_pulse > tgt_pulse) begin
      cur_new = (step < gap) ? cur_pulse - step : tgt_pulse;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic out_load;

  assign in_stall = state != ST_IDLE;
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_PREP;
      ST_PREP: begin
        // Only an initialised set-angle or update needs the divider
        if (initialized && ((op_r == OP_SET_ANGLE) || (op_r == OP_UPDATE))) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MUL:   state_next = ST_START;
      ST_START: state_next = ST_WAIT;
      ST_WAIT:  if (div_rsp.done) state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the command on transfer
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op_r    <= in_data.operation;
      angle_r <= in_data.target_angle;
      pulse_r <= in_data.target_pulse;
      now_r   <= in_data.now_ms;
    end
  end

  // Operand and result registers
  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      seg_dx     <= dx17[15:0];
      seg_den    <= den17[15:0];
      seg_dy_mag <= dy_abs17[15:0];
      seg_dy_neg <= dy17[16];
      seg_y0     <= y0_sel;
      lim_r      <= ang_lim;
      dt_r       <= dt_cap;
      // Init and set-pulse answer here; the divider path overwrites these
      res_ok     <= (op_r == OP_INIT) ? calib_valid
                                      : (initialized && (op_r == OP_SET_PULSE));
      res_lim    <= initialized && (op_r == OP_SET_PULSE) && pulse_lim;
    end
    if (state == ST_MUL) begin
      prod <= 32'(mul_a) * 32'(mul_b);
    end
    if (state == ST_WAIT && div_rsp.done) begin
      if (is_angle) begin
        res_ok  <= p_in_range;
        res_lim <= lim_r;
      end else begin
        res_ok  <= 1'b1;
        res_lim <= 1'b0;
      end
    end
  end

  // Controller state and latched calibration
  always_ff @(posedge clk) begin
    if (rst) begin
      initialized <= 1'b0;
      cur_pulse   <= '0;
      tgt_pulse   <= '0;
      last_time   <= '0;
      motion      <= MS_DISABLED;
      h_pmin      <= RST_PULSE_MIN;
      h_pcen      <= RST_PULSE_CENTER;
      h_pmax      <= RST_PULSE_MAX;
      h_amin      <= RST_ANGLE_MIN;
      h_acen      <= RST_ANGLE_CENTER;
      h_amax      <= RST_ANGLE_MAX;
      h_slew      <= RST_MAX_SLEW;
    end else begin
      if (state == ST_PREP) begin
        if (op_r == OP_INIT) begin
          // Latch calibration and restart from the centre pulse
          if (calib_valid) begin
            h_pmin      <= cfg_pmin;
            h_pcen      <= cfg_pcen;
            h_pmax      <= cfg_pmax;
            h_amin      <= cfg_amin;
            h_acen      <= cfg_acen;
            h_amax      <= cfg_amax;
            h_slew      <= cfg_slew;
            cur_pulse   <= cfg_pcen;
            tgt_pulse   <= cfg_pcen;
            last_time   <= now_r;
            motion      <= MS_DISABLED;
            initialized <= 1'b1;
          end
        end else if (initialized && op_r == OP_SET_PULSE) begin
          tgt_pulse <= pulse_cl;
        end else if (initialized && op_r == OP_UPDATE) begin
          last_time <= now_r;
        end
      end
      if (state == ST_WAIT && div_rsp.done) begin
        if (is_angle) begin
          if (p_in_range) begin
            tgt_pulse <= p18[15:0];
          end
        end else begin
          cur_pulse <= cur_new;
          motion    <= (cur_new == tgt_pulse) ? MS_HOLDING : MS_MOVING;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: hold a stalled result, drop valid once transferred
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.ok            <= res_ok;
      out_data.limited       <= res_lim;
      out_data.current_pulse <= cur_pulse;
      out_data.motion_state  <= motion;
    end
  end

endmodule

[sv/ssp_checker.sv]
// ----------------------------------------------------------------------------
// ssp_checker: port-level checks for the servo slew position controller
// Watches the command and result channels; bound to the top level below.
// ----------------------------------------------------------------------------
module ssp_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input ssp_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input ssp_pkg::out_t out_data
);
  import ssp_pkg::*;

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One command at a time: a transfer closes the command channel
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("command channel open right after a transfer");

  // A new result only appears while a command is in work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no command in work");

  // Clamping is only reported on a successful command
  a_limited_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.limited |-> out_data.ok)
    else $error("limited flagged on a failed command");

endmodule

bind servo_slew_position_controller ssp_checker u_ssp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/servo_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_result_checker: result predictor and comparator for the servo block
// Tracks calibration writes, predicts one report per accepted command and
// compares every report transfer, field by field, against the oldest one due.
// ----------------------------------------------------------------------------
module servo_result_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  ssp_pkg::in_t                  in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  ssp_pkg::out_t                 out_data,
  output int unsigned                   mismatches,
  output int unsigned                   outstanding,
  output int unsigned                   results
);
  import ssp_pkg::*;

  typedef struct packed {
    logic [15:0]        pulse_min;
    logic [15:0]        pulse_center;
    logic [15:0]        pulse_max;
    logic signed [15:0] angle_min;
    logic signed [15:0] angle_center;
    logic signed [15:0] angle_max;
    logic [15:0]        max_slew;
  } calib_t;

  calib_t      cal_live;
  calib_t      cal_used;
  logic        armed;
  logic [15:0] pulse_now;
  logic [15:0] pulse_goal;
  logic [31:0] stamp_ms;
  logic [1:0]  motion;

  out_t        pulse_reports_due [$];
  out_t        due;
  int unsigned bad_count  = 0;
  int unsigned seen_count = 0;

  function automatic bit calib_sound(calib_t c);
    if (c.max_slew == '0 || c.angle_min >= c.angle_center || c.angle_center >= c.angle_max)
      return 1'b0;
    return (c.pulse_min < c.pulse_center && c.pulse_center < c.pulse_max) ||
           (c.pulse_min > c.pulse_center && c.pulse_center > c.pulse_max);
  endfunction

  // Straight line through (x0, y0) and (x1, y1), quotient truncated toward zero
  function automatic longint interp_pulse(int x, int x0, int x1, int y0, int y1);
    longint num;
    longint den;
    num = longint'(x - x0) * longint'(y1 - y0);
    den = longint'(x1) - longint'(x0);
    if (den == 0)
      return longint'(y0);
    return longint'(y0) + num / den;
  endfunction

  function automatic out_t servo_step(in_t cmd);
    out_t        rep;
    int          a;
    longint      p;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] req;
    logic [31:0] dt;
    logic [31:0] stride;
    logic [31:0] next_up;
    logic [31:0] gap;
    rep = '0;
    case (op_e'(cmd.operation))
      OP_INIT: begin
        if (calib_sound(cal_live)) begin
          cal_used   = cal_live;
          pulse_now  = cal_live.pulse_center;
          pulse_goal = cal_live.pulse_center;
          stamp_ms   = cmd.now_ms;
          motion     = MS_DISABLED;
          armed      = 1'b1;
          rep.ok     = 1'b1;
        end
      end
      OP_SET_ANGLE: if (armed) begin
        a = int'($signed(cmd.target_angle));
        if (a < int'(cal_used.angle_min)) begin
          a = int'(cal_used.angle_min);
          rep.limited = 1'b1;
        end else if (a > int'(cal_used.angle_max)) begin
          a = int'(cal_used.angle_max);
          rep.limited = 1'b1;
        end
        if (a <= int'(cal_used.angle_center))
          p = interp_pulse(a, int'(cal_used.angle_min), int'(cal_used.angle_center),
                           int'(cal_used.pulse_min), int'(cal_used.pulse_center));
        else
          p = interp_pulse(a, int'(cal_used.angle_center), int'(cal_used.angle_max),
                           int'(cal_used.pulse_center), int'(cal_used.pulse_max));
        if (p >= 0 && p <= 65535) begin
          pulse_goal = p[15:0];
          rep.ok     = 1'b1;
        end
      end
      OP_SET_PULSE: if (armed) begin
        lo  = (cal_used.pulse_min < cal_used.pulse_max) ? cal_used.pulse_min : cal_used.pulse_max;
        hi  = (cal_used.pulse_min > cal_used.pulse_max) ? cal_used.pulse_min : cal_used.pulse_max;
        req = cmd.target_pulse;
        if (req < lo) begin
          req = lo;
          rep.limited = 1'b1;
        end else if (req > hi) begin
          req = hi;
          rep.limited = 1'b1;
        end
        pulse_goal = req;
        rep.ok     = 1'b1;
      end
      OP_UPDATE: if (armed) begin
        dt       = cmd.now_ms - stamp_ms;
        stamp_ms = cmd.now_ms;
        if (dt > 32'(DT_CAP_MS))
          dt = 32'(DT_CAP_MS);
        stride = (32'(cal_used.max_slew) * dt) / 32'(MS_PER_S);
        // any elapsed time moves by at least one microsecond
        if (dt != 0 && stride == 0)
          stride = 1;
        if (pulse_now < pulse_goal) begin
          next_up   = 32'(pulse_now) + stride;
          pulse_now = (next_up < 32'(pulse_goal)) ? next_up[15:0] : pulse_goal;
        end else if (pulse_now > pulse_goal) begin
          gap       = 32'(pulse_now) - 32'(pulse_goal);
          pulse_now = (stride < gap) ? pulse_now - stride[15:0] : pulse_goal;
        end
        motion = (pulse_now == pulse_goal) ? MS_HOLDING : MS_MOVING;
        rep.ok = 1'b1;
      end
    endcase
    rep.current_pulse = pulse_now;
    rep.motion_state  = motion;
    return rep;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cal_live   = '{RST_PULSE_MIN, RST_PULSE_CENTER, RST_PULSE_MAX, RST_ANGLE_MIN,
                     RST_ANGLE_CENTER, RST_ANGLE_MAX, RST_MAX_SLEW};
      cal_used   = cal_live;
      armed      = 1'b0;
      pulse_now  = '0;
      pulse_goal = '0;
      stamp_ms   = '0;
      motion     = MS_DISABLED;
      pulse_reports_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_PULSE_MIN:    cal_live.pulse_min    = cfg_data;
          REG_PULSE_CENTER: cal_live.pulse_center = cfg_data;
          REG_PULSE_MAX:    cal_live.pulse_max    = cfg_data;
          REG_ANGLE_MIN:    cal_live.angle_min    = cfg_data;
          REG_ANGLE_CENTER: cal_live.angle_center = cfg_data;
          REG_ANGLE_MAX:    cal_live.angle_max    = cfg_data;
          REG_MAX_SLEW:     cal_live.max_slew     = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        pulse_reports_due.push_back(servo_step(in_data));
      if (out_valid && !out_stall) begin
        seen_count++;
        if (pulse_reports_due.size() == 0) begin
          if (bad_count < 10)
            $display("%0t: report with nothing due: ok %0b limited %0b pulse %0d state %0d",
                     $time, out_data.ok, out_data.limited, out_data.current_pulse,
                     out_data.motion_state);
          bad_count++;
        end else begin
          due = pulse_reports_due.pop_front();
          if (out_data.ok !== due.ok || out_data.limited !== due.limited ||
              out_data.current_pulse !== due.current_pulse ||
              out_data.motion_state !== due.motion_state) begin
            if (bad_count < 10)
              $display("%0t: report differs (expected/actual): ok %0b/%0b limited %0b/%0b %s",
                       $time, due.ok, out_data.ok, due.limited, out_data.limited,
                       $sformatf("pulse %0d/%0d state %0d/%0d", due.current_pulse,
                                 out_data.current_pulse, due.motion_state,
                                 out_data.motion_state));
            bad_count++;
          end
        end
      end
    end
    mismatches  <= bad_count;
    outstanding <= pulse_reports_due.size();
    results     <= seen_count;
  end

endmodule

[tb/tb_servo_slew_position_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_servo_slew_position_controller: command stimulus and verdict
// Drives directed and random servo commands and calibration settings with
// random gaps and result back-pressure; the result checker beside the block
// predicts and compares every report and hands back its failure count.
// ----------------------------------------------------------------------------
module tb_servo_slew_position_controller;
  import ssp_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 50;
  localparam int unsigned RANDOM_PHASES   = 11;
  localparam int unsigned PHASE_ITEMS     = 47;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results;

  // Stimulus bookkeeping
  bit          idle_en;
  bit          hold_off_req;
  int unsigned hold_left;
  logic [31:0] ms_clock;
  int unsigned sent_by_op [4];
  int unsigned settings_used;

  // Ranges of the last programmed calibration, used to aim commands in range
  logic signed [15:0] span_amin;
  logic signed [15:0] span_amax;
  logic [15:0]        span_plo;
  logic [15:0]        span_phi;

  always #2 clk = ~clk;

  servo_slew_position_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  servo_result_checker watch (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .results     (results)
  );

  // Offer one command and hold it until the transfer happens. A gap, when
  // drawn, drops valid first; otherwise valid stays high across commands.
  task automatic send_cmd(input op_e op, input logic signed [15:0] ang,
                          input logic [15:0] pul, input logic [31:0] stamp);
    in_t cmd;
    cmd.operation    = op;
    cmd.target_angle = ang;
    cmd.target_pulse = pul;
    cmd.now_ms       = stamp;
    if (idle_en && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_by_op[op]++;
  endtask

  // Drop valid and wait until every report due has been transferred. The
  // first edge lets the checker count a command accepted at this very edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write all seven calibration registers back to back while the block idles
  task automatic program_cal(input logic [15:0] pmin, pcen, pmax,
                             input logic signed [15:0] amin, acen, amax,
                             input logic [15:0] slew);
    logic [CFG_IDX_W-1:0] idx [7];
    logic [15:0]          val [7];
    idx = '{REG_PULSE_MIN, REG_PULSE_CENTER, REG_PULSE_MAX, REG_ANGLE_MIN,
            REG_ANGLE_CENTER, REG_ANGLE_MAX, REG_MAX_SLEW};
    val = '{pmin, pcen, pmax, amin, acen, amax, slew};
    wait_drained();
    for (int i = 0; i < 7; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    span_amin = amin;
    span_amax = amax;
    span_plo  = (pmin < pmax) ? pmin : pmax;
    span_phi  = (pmin > pmax) ? pmin : pmax;
    settings_used++;
  endtask

  // Draw a calibration: narrow or wide segments, either pulse direction,
  // small or large slew; a broken one spoils exactly one validity rule.
  task automatic program_random_cal(input bit broken);
    int                 d1, d2, base, e1, e2, abase;
    logic [15:0]        p0, p1, p2, tmp, slew;
    logic signed [15:0] a0, a1, a2;
    d1    = $urandom_range(1) ? $urandom_range(1, 150) : $urandom_range(1, 20000);
    d2    = $urandom_range(1) ? $urandom_range(1, 150) : $urandom_range(1, 20000);
    base  = $urandom_range(0, 65535 - d1 - d2);
    p0    = 16'(base);
    p1    = 16'(base + d1);
    p2    = 16'(base + d1 + d2);
    if ($urandom_range(1)) begin
      tmp = p0;
      p0  = p2;
      p2  = tmp;
    end
    e1    = $urandom_range(1) ? $urandom_range(1, 400) : $urandom_range(1, 25000);
    e2    = $urandom_range(1) ? $urandom_range(1, 400) : $urandom_range(1, 25000);
    abase = -32768 + int'($urandom_range(0, 65535 - e1 - e2));
    a0    = 16'(abase);
    a1    = 16'(abase + e1);
    a2    = 16'(abase + e1 + e2);
    slew  = $urandom_range(1) ? 16'($urandom_range(1, 40)) : 16'($urandom_range(1, 65535));
    if (broken) begin
      case ($urandom_range(2))
        0:       slew = '0;
        1:       a1 = a2;
        default: p1 = p2;
      endcase
    end
    program_cal(p0, p1, p2, a0, a1, a2, slew);
  endtask

  // Mostly ticks and set-points aimed inside the calibrated span, some raw
  // values, a rare re-init, and time that usually creeps but now and then jumps
  task automatic send_random_cmd();
    int                 pick, span;
    op_e                op;
    logic signed [15:0] ang;
    logic [15:0]        pul;
    pick = $urandom_range(99);
    op   = (pick < 4) ? OP_INIT : (pick < 30) ? OP_SET_ANGLE :
           (pick < 50) ? OP_SET_PULSE : OP_UPDATE;
    span = int'(span_amax) - int'(span_amin);
    if (span < 0)
      span = 0;
    ang  = ($urandom_range(3) == 0) ? 16'($urandom) :
           16'(int'(span_amin) + int'($urandom_range(0, span)));
    span = int'(span_phi) - int'(span_plo);
    pul  = ($urandom_range(3) == 0) ? 16'($urandom) :
           16'(int'(span_plo) + int'($urandom_range(0, span)));
    if ($urandom_range(24) == 0)
      ms_clock = $urandom;
    else
      ms_clock = ms_clock + $urandom_range(0, 120);
    send_cmd(op, ang, pul, ms_clock);
  endtask

  // Result side: random stalls, plus one long hold-off on request so the
  // output register fills and the block stalls its command input.
  initial begin
    out_stall <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_en && ($urandom_range(99) < 17);
      end
    end
  end

  // Guard against a hung handshake
  initial begin
    #2_000_000;
    $display("[servo_slew_position_controller] ERROR");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    idle_en       = 1'b1;
    hold_off_req  = 1'b0;
    ms_clock      = '0;
    settings_used = 0;
    sent_by_op    = '{default: 0};
    span_amin     = RST_ANGLE_MIN;
    span_amax     = RST_ANGLE_MAX;
    span_plo      = RST_PULSE_MIN;
    span_phi      = RST_PULSE_MAX;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset calibration: commands before init must be refused untouched
    send_cmd(OP_SET_ANGLE, 16'sd0, 16'd0, 32'd0);
    send_cmd(OP_SET_PULSE, 16'sd0, 16'd1700, 32'd0);
    send_cmd(OP_UPDATE, 16'sd0, 16'd0, 32'd10);
    send_cmd(OP_INIT, 16'sd0, 16'd0, 32'd1000);
    // Angles past both limits, the exact lower limit, and truncation on either side
    send_cmd(OP_SET_ANGLE, 16'sh8000, 16'd0, 32'd0);
    send_cmd(OP_SET_ANGLE, 16'sh7FFF, 16'd0, 32'd0);
    send_cmd(OP_SET_ANGLE, -16'sd9000, 16'd0, 32'd0);
    send_cmd(OP_SET_ANGLE, -16'sd4501, 16'd0, 32'd0);
    send_cmd(OP_SET_ANGLE, 16'sd4501, 16'd0, 32'd0);
    // Pulses below and above the span, then one inside it
    send_cmd(OP_SET_PULSE, 16'sd0, 16'd0, 32'd0);
    send_cmd(OP_SET_PULSE, 16'sd0, 16'hFFFF, 32'd0);
    send_cmd(OP_SET_PULSE, 16'sd0, 16'd1999, 32'd0);
    // No elapsed time, one millisecond, a capped gap, and a wrap of the clock
    send_cmd(OP_UPDATE, 16'sd0, 16'd0, 32'd1000);
    send_cmd(OP_UPDATE, 16'sd0, 16'd0, 32'd1001);
    send_cmd(OP_UPDATE, 16'sd0, 16'd0, 32'hFFFF_FFF0);
    send_cmd(OP_UPDATE, 16'sd0, 16'd0, 32'h0000_0010);

    // Widest calibration with a falling pulse, full slew
    program_cal(16'hFFFF, 16'h8000, 16'h0000, 16'sh8000, 16'sd0, 16'sh7FFF, 16'hFFFF);
    send_cmd(OP_INIT, 16'sd0, 16'd0, 32'd0);
    send_cmd(OP_SET_ANGLE, 16'sh8000, 16'd0, 32'd0);
    send_cmd(OP_SET_ANGLE, 16'sd1, 16'd0, 32'd0);
    send_cmd(OP_UPDATE, 16'sd0, 16'd0, 32'd100);

    // Each broken calibration is refused; the latched one stays in force
    program_cal(RST_PULSE_MIN, RST_PULSE_CENTER, RST_PULSE_MAX, RST_ANGLE_MIN,
                RST_ANGLE_CENTER, RST_ANGLE_MAX, 16'd0);
    send_cmd(OP_INIT, 16'sd0, 16'd0, 32'd200);
    send_cmd(OP_SET_PULSE, 16'sd0, 16'd5, 32'd0);
    program_cal(16'd1000, 16'd1000, 16'd2000, RST_ANGLE_MIN, RST_ANGLE_CENTER,
                RST_ANGLE_MAX, RST_MAX_SLEW);
    send_cmd(OP_INIT, 16'sd0, 16'd0, 32'd300);
    program_cal(RST_PULSE_MIN, RST_PULSE_CENTER, RST_PULSE_MAX, RST_ANGLE_MIN,
                RST_ANGLE_MAX, RST_ANGLE_MAX, RST_MAX_SLEW);
    send_cmd(OP_INIT, 16'sd0, 16'd0, 32'd400);

    // Tightest valid calibration: slowest slew, where the step rounds up to one
    program_cal(16'd0, 16'd1, 16'd2, -16'sd1, 16'sd0, 16'sd1, 16'd1);
    send_cmd(OP_INIT, 16'sd0, 16'd0, 32'd500);
    send_cmd(OP_SET_ANGLE, 16'sd1, 16'd0, 32'd0);
    send_cmd(OP_UPDATE, 16'sd0, 16'd0, 32'd501);
    ms_clock = 32'd501;

    // Random phases: fresh calibration each time, one stretch without any
    // idling, and one where the result side holds off for a long while
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      program_random_cal(ph % 4 == 2);
      idle_en = (ph != 3);
      send_cmd(OP_INIT, 16'sd0, 16'd0, ms_clock);
      if (ph == 5)
        hold_off_req = 1'b1;
      repeat (PHASE_ITEMS) send_random_cmd();
    end
    idle_en = 1'b1;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands: %0d init, %0d set-angle, %0d set-pulse, %0d tick",
             sent_by_op[OP_INIT] + sent_by_op[OP_SET_ANGLE] + sent_by_op[OP_SET_PULSE] +
             sent_by_op[OP_UPDATE], sent_by_op[OP_INIT], sent_by_op[OP_SET_ANGLE],
             sent_by_op[OP_SET_PULSE], sent_by_op[OP_UPDATE]);
    $display("Checked %0d reports across %0d calibration settings, %0d left due",
             results, settings_used, outstanding);
    if (mismatches == 0 && outstanding == 0)
      $display("[servo_slew_position_controller] OK");
    else
      $display("[servo_slew_position_controller] ERROR");
    $finish;
  end

endmodule

[files.f]
sv/ssp_pkg.sv
sv/ssp_div.sv
sv/servo_slew_position_controller.sv
sv/ssp_checker.sv
tb/servo_result_checker.sv
tb/tb_servo_slew_position_controller.sv
